>>> rtl/ipm_pkg.sv
// Shared constants, codes and control structs of the integer polynomial multiplier.
`timescale 1ns / 1ps

package ipm_pkg;

  // Store geometry and field widths.
  localparam int MAX_COEFS  = 512;
  localparam int COEF_BITS  = 16;
  localparam int ADDR_BITS  = $clog2(MAX_COEFS);
  localparam int IDX_BITS   = 10;
  localparam int CNT_BITS   = 10;
  localparam int MUL_BITS   = 2 * COEF_BITS;
  localparam int PROD_BITS  = 41;

  // Reset value of the coefficient count register.
  localparam logic [CNT_BITS-1:0] COUNT_RESET = CNT_BITS'(512);

  // Request operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // request taken this cycle
    logic setup;     // compute the summation range of a read
    logic issue;     // launch one multiply-accumulate term
    logic load_out;  // move the finished result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_err;  // read index outside the product
    logic last;       // the term being issued is the final one
    logic pipe_busy;  // terms still in flight in the multiply pipeline
  } dp_stat_t;

endpackage

>>> rtl/ipm_ctrl.sv
// Controller state machine that sequences loads and product reads.
`timescale 1ns / 1ps

module ipm_ctrl
  import ipm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SETUP  = 5'b00010,
    S_RUN    = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // The output register can take a new result when empty or being drained.
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_op == OP_READ) ? S_SETUP : S_FINISH;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = stat.range_err ? S_FINISH : S_RUN;
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (stat.last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid flag follows loads and downstream takes.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/ipm_dp.sv
// Datapath: operand stores, summation range, multiply-accumulate and output register.
`timescale 1ns / 1ps

module ipm_dp
  import ipm_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  dp_cmd_t                     cmd,
  output dp_stat_t                    stat,
  input  logic                        in_op,
  input  logic [IDX_BITS-1:0]         in_index,
  input  logic signed [COEF_BITS-1:0] in_a_coef,
  input  logic signed [COEF_BITS-1:0] in_b_coef,
  input  logic                        cfg_valid,
  input  logic [CNT_BITS-1:0]         cfg_coef_count,
  output logic signed [PROD_BITS-1:0] out_product_coef,
  output logic                        out_status
);

  // Operand stores.
  logic signed [COEF_BITS-1:0] a_mem [MAX_COEFS];
  logic signed [COEF_BITS-1:0] b_mem [MAX_COEFS];

  logic [CNT_BITS-1:0]         coef_count_r;
  logic [CNT_BITS-1:0]         n_cnt;
  logic [IDX_BITS-1:0]         k_r;
  logic                        stat_r;
  logic [ADDR_BITS-1:0]        i_r;
  logic [ADDR_BITS-1:0]        j_r;
  logic [CNT_BITS-1:0]         cnt_r;
  logic                        v1_r;
  logic                        v2_r;
  logic signed [COEF_BITS-1:0] rd_a_r;
  logic signed [COEF_BITS-1:0] rd_b_r;
  logic signed [MUL_BITS-1:0]  mul_r;
  logic signed [PROD_BITS-1:0] mul_ext;
  logic signed [PROD_BITS-1:0] acc_r;
  logic signed [PROD_BITS-1:0] out_product_r;
  logic                        out_status_r;
  logic                        wr_en;
  logic [IDX_BITS:0]           k_p1;
  logic [IDX_BITS:0]           n_x2;
  logic [CNT_BITS-1:0]         lo;
  logic [CNT_BITS-1:0]         hi;
  logic [CNT_BITS-1:0]         terms;
  logic [CNT_BITS-1:0]         j_start;

  // Coefficient count register, written from the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_count_r <= COUNT_RESET;
    end else if (cfg_valid) begin
      coef_count_r <= cfg_coef_count;
    end
  end

  // Effective count saturates at the store depth.
  assign n_cnt = (coef_count_r > CNT_BITS'(MAX_COEFS)) ? CNT_BITS'(MAX_COEFS) : coef_count_r;

  // A load writes both stores when its index lies inside the polynomials.
  assign wr_en = cmd.accept && (in_op == OP_LOAD) && (in_index < n_cnt);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      a_mem[in_index[ADDR_BITS-1:0]] <= in_a_coef;
    end
    rd_a_r <= a_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      b_mem[in_index[ADDR_BITS-1:0]] <= in_b_coef;
    end
    rd_b_r <= b_mem[j_r];
  end

  // Summation range of product coefficient k: i from lo to hi, j = k - i.
  always_comb begin
    k_p1    = {1'b0, k_r} + (IDX_BITS + 1)'(1);
    n_x2    = {n_cnt, 1'b0};
    lo      = (k_r >= n_cnt) ? (k_r - n_cnt + CNT_BITS'(1)) : '0;
    hi      = (k_r < n_cnt) ? k_r : (n_cnt - CNT_BITS'(1));
    terms   = hi - lo + CNT_BITS'(1);
    j_start = k_r - lo;
  end

  // The product has 2n-1 coefficients, so k is out of range once k+1 reaches 2n.
  assign stat.range_err = (k_p1 >= n_x2);
  assign stat.last      = (cnt_r == CNT_BITS'(1));
  assign stat.pipe_busy = v1_r || v2_r;

  // Request index, status and term walk.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      k_r    <= in_index;
      stat_r <= (in_index < n_cnt) ? STATUS_OK : STATUS_RANGE;
    end
    if (cmd.setup) begin
      stat_r <= stat.range_err ? STATUS_RANGE : STATUS_OK;
      i_r    <= lo[ADDR_BITS-1:0];
      j_r    <= j_start[ADDR_BITS-1:0];
      cnt_r  <= terms;
    end else if (cmd.issue) begin
      i_r   <= i_r + ADDR_BITS'(1);
      j_r   <= j_r - ADDR_BITS'(1);
      cnt_r <= cnt_r - CNT_BITS'(1);
    end
  end

  // Valid tags of the read and multiply stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  // Multiply stage, then accumulate.
  assign mul_ext = {{(PROD_BITS - MUL_BITS){mul_r[MUL_BITS-1]}}, mul_r};

  always_ff @(posedge clk) begin
    if (v1_r) begin
      mul_r <= rd_a_r * rd_b_r;
    end
    if (cmd.accept) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + mul_ext;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_product_r <= acc_r;
      out_status_r  <= stat_r;
    end
  end

  assign out_product_coef = out_product_r;
  assign out_status       = out_status_r;

endmodule

>>> rtl/integer_polynomial_multiplier.sv
// Integer polynomial multiplier top level: controller plus datapath.
// A load goes from acceptance to the finish state, where its result enters the output register.
// A read steps through setup, run and drain, or from setup to finish when out of range, on
// one shared multiply-accumulate unit that reads one operand pair per cycle from the two stores.
// A stalled result holds the next request in its finish state until the output register is free.
// Synchronous active-low reset clears control state and sets coef_count to 512, not the stores.
`timescale 1ns / 1ps

module integer_polynomial_multiplier
  import ipm_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic [IDX_BITS-1:0]         in_index,
  input  logic signed [COEF_BITS-1:0] in_a_coef,
  input  logic signed [COEF_BITS-1:0] in_b_coef,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [PROD_BITS-1:0] out_product_coef,
  output logic                        out_status,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CNT_BITS-1:0]         cfg_coef_count
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration writes are taken at any time.
  assign cfg_ready = 1'b1;

  ipm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  ipm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_op            (in_op),
    .in_index         (in_index),
    .in_a_coef        (in_a_coef),
    .in_b_coef        (in_b_coef),
    .cfg_valid        (cfg_valid),
    .cfg_coef_count   (cfg_coef_count),
    .out_product_coef (out_product_coef),
    .out_status       (out_status)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the integer polynomial multiplier.
`timescale 1ns / 1ps

module tb;
  import ipm_pkg::*;

  localparam int RANDOM_PER_COUNT = 38;
  localparam int HOLD_CYCLES      = 300;
  localparam int DRAIN_CYCLES     = 520;
  localparam int REPORT_LIMIT     = 40;
  localparam logic signed [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam logic signed [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};

  typedef struct packed {
    logic                        op;
    logic [IDX_BITS-1:0]         index;
    logic signed [COEF_BITS-1:0] a_coef;
    logic signed [COEF_BITS-1:0] b_coef;
  } coef_request_t;

  typedef struct packed {
    logic signed [PROD_BITS-1:0] product;
    logic                        status;
  } coef_result_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        in_op = OP_LOAD;
  logic [IDX_BITS-1:0]         in_index = '0;
  logic signed [COEF_BITS-1:0] in_a_coef = '0;
  logic signed [COEF_BITS-1:0] in_b_coef = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [PROD_BITS-1:0] out_product_coef;
  logic                        out_status;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CNT_BITS-1:0]         cfg_coef_count = '0;

  // Shadow copy of the operand stores and the count register.
  logic signed [COEF_BITS-1:0] first_coefs [MAX_COEFS];
  logic signed [COEF_BITS-1:0] second_coefs [MAX_COEFS];
  logic [CNT_BITS-1:0]         coef_count_cfg = COUNT_RESET;
  bit                          loaded [MAX_COEFS];

  coef_request_t request_queue [$];
  coef_result_t  expected_coefs [$];
  coef_request_t driven_request;

  int unsigned requests_made, results_checked, mismatch_count;
  int unsigned loads_done, reads_done, range_errors, counts_tried;
  int unsigned gap_left, burst_left;
  int unsigned hold_left, mode_left, stall_tick;
  bit          hold_done, pressure_armed;
  stall_mode_t stall_mode = STALL_NONE;

  int unsigned count_plan [13] = '{1, 2, 3, 7, 16, 33, 64, 0, 512, 1023, 100, 5, 200};

  integer_polynomial_multiplier dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_index        (in_index),
    .in_a_coef       (in_a_coef),
    .in_b_coef       (in_b_coef),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_product_coef(out_product_coef),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_coef_count  (cfg_coef_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // The count register saturates at the store depth.
  function automatic int unsigned effective_count();
    return (coef_count_cfg > MAX_COEFS) ? MAX_COEFS : int'(coef_count_cfg);
  endfunction

  // Applies one request to the shadow stores and returns the result it must produce.
  function automatic coef_result_t predict_coef(coef_request_t req);
    coef_result_t res;
    int unsigned  n, k, lo, hi, i;
    longint       acc;
    res.product = '0;
    res.status  = STATUS_OK;
    n = effective_count();
    k = req.index;
    if (req.op == OP_LOAD) begin
      if (k < n) begin
        first_coefs[k]  = req.a_coef;
        second_coefs[k] = req.b_coef;
      end else begin
        res.status = STATUS_RANGE;
      end
    end else if (n == 0 || k > 2 * n - 2) begin
      res.status = STATUS_RANGE;
    end else begin
      lo  = (k >= n) ? k - (n - 1) : 0;
      hi  = (k < n) ? k : n - 1;
      acc = 0;
      for (i = lo; i <= hi; i++) begin
        acc += longint'(first_coefs[i]) * longint'(second_coefs[k - i]);
      end
      res.product = acc[PROD_BITS-1:0];
    end
    return res;
  endfunction

  // Extremes come up often so that sign corners are hit in sums.
  function automatic logic signed [COEF_BITS-1:0] random_coef();
    case ($urandom_range(0, 11))
      0: return COEF_MIN;
      1: return COEF_MAX;
      2: return '0;
      3: return '1;
      default: return COEF_BITS'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
  endtask

  // Queues one request and notes which store entries it will have written.
  task automatic queue_request(input logic op, input int unsigned idx,
                               input logic signed [COEF_BITS-1:0] a,
                               input logic signed [COEF_BITS-1:0] b);
    coef_request_t req;
    req.op     = op;
    req.index  = IDX_BITS'(idx);
    req.a_coef = a;
    req.b_coef = b;
    if (op == OP_LOAD && idx < effective_count()) begin
      loaded[idx] = 1'b1;
    end
    request_queue.push_back(req);
    requests_made++;
  endtask

  // Waits until every queued request has returned its result.
  task automatic drain_results();
    do @(posedge clk); while (results_checked != requests_made);
  endtask

  task automatic write_coef_count(input logic [CNT_BITS-1:0] value);
    cfg_coef_count <= value;
    cfg_valid      <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid      <= 1'b0;
    coef_count_cfg = value;
    counts_tried++;
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      gap_left   <= 0;
      burst_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_coefs.push_back(predict_coef(driven_request));
        if (driven_request.op == OP_LOAD) loads_done++;
        else reads_done++;
        if (expected_coefs[$].status == STATUS_RANGE) range_errors++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 || request_queue.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else begin
          driven_request = request_queue.pop_front();
          in_valid  <= 1'b1;
          in_op     <= driven_request.op;
          in_index  <= driven_request.index;
          in_a_coef <= driven_request.a_coef;
          in_b_coef <= driven_request.b_coef;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Result stall pattern, with one long hold-off once the pressure phase starts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
      mode_left  <= 64;
      stall_mode <= STALL_NONE;
      stall_tick <= 0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (pressure_armed && !hold_done) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode <= stall_mode_t'($urandom_range(0, 3));
          mode_left  <= $urandom_range(32, 256);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
          STALL_PERIODIC: out_stall <= ((stall_tick % 7) < 3);
          default:        out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Result monitor: each accepted result is compared against the oldest prediction.
  always @(posedge clk) begin
    coef_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_coefs.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        want = expected_coefs.pop_front();
        results_checked++;
        if (out_product_coef !== want.product) begin
          report_mismatch($sformatf("product_coef %0d, expected %0d",
                                    out_product_coef, want.product));
        end
        if (out_status !== want.status) begin
          report_mismatch($sformatf("status %0b, expected %0b", out_status, want.status));
        end
      end
    end
  end

  initial begin
    int unsigned n, start, pick, idx, p, k;
    for (idx = 0; idx < MAX_COEFS; idx++) begin
      first_coefs[idx]  = '0;
      second_coefs[idx] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset count: top entry, loads past the end, and the two highest reads.
    queue_request(OP_LOAD, MAX_COEFS - 1, COEF_MIN, COEF_MIN);
    queue_request(OP_LOAD, MAX_COEFS, COEF_MAX, COEF_MAX);
    queue_request(OP_LOAD, 1023, '1, '1);
    queue_request(OP_READ, 2 * MAX_COEFS - 2, '0, '0);
    queue_request(OP_READ, 1023, '0, '0);
    drain_results();

    // Four coefficients with extreme values, then every product term and the edges.
    write_coef_count(CNT_BITS'(4));
    queue_request(OP_LOAD, 0, COEF_MAX, COEF_MIN);
    queue_request(OP_LOAD, 1, '1, COEF_MAX);
    queue_request(OP_LOAD, 2, '0, '1);
    queue_request(OP_LOAD, 3, COEF_MIN, COEF_MIN);
    queue_request(OP_LOAD, 4, COEF_MAX, COEF_MAX);
    for (k = 0; k <= 7; k++) queue_request(OP_READ, k, '0, '0);
    queue_request(OP_READ, 1023, '0, '0);
    drain_results();

    // One phase per count setting: fill unwritten entries, then a random mix.
    for (p = 0; p < $size(count_plan); p++) begin
      drain_results();
      write_coef_count(CNT_BITS'(count_plan[p]));
      n = effective_count();
      if (n == MAX_COEFS) pressure_armed = 1'b1;
      if (n != 0) begin
        start = $urandom_range(0, n - 1);
        for (k = 0; k < n; k++) begin
          idx = (start + k) % n;
          if (!loaded[idx]) queue_request(OP_LOAD, idx, random_coef(), random_coef());
          if ($urandom_range(0, 9) == 0) queue_request(OP_LOAD, $urandom_range(n, 1023),
                                                       random_coef(), random_coef());
        end
      end
      repeat (RANDOM_PER_COUNT) begin
        pick = $urandom_range(0, 99);
        if (n == 0) begin
          queue_request(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                        random_coef(), random_coef());
        end else if (pick < 35) begin
          queue_request(OP_LOAD, $urandom_range(0, n - 1), random_coef(), random_coef());
        end else if (pick < 45) begin
          queue_request(OP_LOAD, $urandom_range(n, 1023), random_coef(), random_coef());
        end else if (pick < 92) begin
          queue_request(OP_READ, $urandom_range(0, 2 * n - 2), random_coef(), random_coef());
        end else begin
          queue_request(OP_READ, $urandom_range(2 * n - 1, 1023), random_coef(), random_coef());
        end
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results: %0d loads and %0d reads, %0d of them out of range.",
             results_checked, loads_done, reads_done, range_errors);
    $display("Count register took %0d settings, from zero through saturation.", counts_tried);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #30_000_000;
    $display("Timeout with %0d of %0d results checked.", results_checked, requests_made);
    $display("Mismatches found");
    $finish;
  end

endmodule
